FILE: src/adm_pkg.sv
package adm_pkg;

   // Graph size
   localparam int MAX_NODES = 16;
   localparam int VTX_W     = $clog2(MAX_NODES);
   localparam int CNT_W     = $clog2(MAX_NODES + 1);

   // Field widths fixed by the interface
   localparam int ROW_INDEX_W  = 4;
   localparam int ROW_BITS_W   = 16;
   localparam int VERTEX_W     = 5;
   localparam int NODE_COUNT_W = 5;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NODE_COUNT   = 1'b0,
      CSR_START_VERTEX = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      W_IDLE,
      W_START,
      W_PUSH,
      W_SCAN,
      W_RDSTK,
      W_RDADJ
   } walk_state_type;

   typedef struct packed {
      logic [VTX_W-1:0] vertex;
      logic [CNT_W-1:0] scan;
   } stack_entry_type;

   typedef struct packed {
      logic                   valid;
      logic [ROW_INDEX_W-1:0] row_index;
      logic [ROW_BITS_W-1:0]  row_bits;
      logic                   last_row;
   } load_type;

   typedef struct packed {
      logic [NODE_COUNT_W-1:0] node_count;
      logic [NODE_COUNT_W-1:0] start_vertex;
   } cfg_type;

   typedef struct packed {
      logic                valid;
      logic [VERTEX_W-1:0] vertex;
      logic                last;
   } emit_type;

   typedef struct packed {
      logic             found;
      logic [VTX_W-1:0] index;
   } first_set_type;

   // Bits below the effective vertex count
   function automatic logic [MAX_NODES-1:0] in_use_mask(input logic [NODE_COUNT_W-1:0] n);
      logic [MAX_NODES-1:0] m;
      for (int i = 0; i < MAX_NODES; i++) begin
         m[i] = (i < int'(n));
      end
      return m;
   endfunction

   // Bits at or above the scan position
   function automatic logic [MAX_NODES-1:0] scan_mask(input logic [CNT_W-1:0] s);
      logic [MAX_NODES-1:0] m;
      for (int i = 0; i < MAX_NODES; i++) begin
         m[i] = (i >= int'(s));
      end
      return m;
   endfunction

   // Lowest set bit
   function automatic first_set_type first_set(input logic [MAX_NODES-1:0] v);
      first_set_type r;
      r.found = 1'b0;
      r.index = '0;
      for (int i = MAX_NODES - 1; i >= 0; i--) begin
         if (v[i]) begin
            r.found = 1'b1;
            r.index = VTX_W'(i);
         end
      end
      return r;
   endfunction

endpackage

FILE: src/adm_req_if.sv
interface adm_req_if;
   import adm_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [ROW_INDEX_W-1:0] row_index;
   logic [ROW_BITS_W-1:0]  row_bits;
   logic                   last_row;

   modport source (output valid, output row_index, output row_bits, output last_row,
                   input ready);
   modport sink   (input valid, input row_index, input row_bits, input last_row,
                   output ready);
endinterface

FILE: src/adm_rsp_if.sv
interface adm_rsp_if;
   import adm_pkg::*;

   logic                valid;
   logic                ready;
   logic [VERTEX_W-1:0] vertex;
   logic                last_visit;

   modport source (output valid, output vertex, output last_visit, input ready);
   modport sink   (input valid, input vertex, input last_visit, output ready);
endinterface

FILE: src/adjacency_matrix_dfs_order_top.sv
// Depth-first walk of a graph of up to 16 vertices held as an adjacency matrix.
// Each request transfer stores one 16-bit matrix row; a transfer with last_row
// set stores its row and then walks the graph from start_vertex, returning one
// response transfer per visited vertex (one-based, lowest unvisited neighbor
// first) with last_visit on the final one. A bad start vertex (zero or above
// node_count clamped to 16) gives a single response of vertex 0 with last_visit
// set. Rows are taken back to back while idle. A walk has a setup step, a
// stack push and row scan per visited vertex, and a stack read, row read and
// rescan per return to a parent vertex, as the reads of the stack and row
// memories are registered. Response back-pressure stalls the walk. No request
// is taken during a walk.
// Write node_count and start_vertex only while the block is idle.
module adjacency_matrix_dfs_order_top (
   input  logic                             clock,
   input  logic                             reset,
   adm_req_if.sink                          req_chan,
   adm_rsp_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  logic [adm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [adm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import adm_pkg::*;

   cfg_type  cfg_ff;
   load_type load;
   emit_type emit;
   logic     load_ready;
   logic     out_free;

   logic                rsp_valid_ff;
   logic [VERTEX_W-1:0] rsp_vertex_ff;
   logic                rsp_last_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_count   <= NODE_COUNT_W'(16);
         cfg_ff.start_vertex <= NODE_COUNT_W'(1);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_NODE_COUNT:   cfg_ff.node_count   <= NODE_COUNT_W'(csr_wdata);
            CSR_START_VERTEX: cfg_ff.start_vertex <= NODE_COUNT_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   // Request side: a transfer goes straight into the row memory
   assign req_chan.ready = load_ready;
   assign load = '{valid:     req_chan.valid && load_ready,
                   row_index: req_chan.row_index,
                   row_bits:  req_chan.row_bits,
                   last_row:  req_chan.last_row};

   // Response register: refill in the same cycle it drains
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid) begin
         rsp_vertex_ff <= emit.vertex;
         rsp_last_ff   <= emit.last;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.vertex     = rsp_vertex_ff;
   assign rsp_chan.last_visit = rsp_last_ff;

   adm_walk u_walk (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .load_ready (load_ready),
      .cfg        (cfg_ff),
      .emit       (emit),
      .out_free   (out_free)
   );
endmodule

FILE: src/adm_ram.sv
module adm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

FILE: src/adm_walk.sv
module adm_walk (
   input  logic              clock,
   input  logic              reset,
   input  adm_pkg::load_type load,
   output logic              load_ready,
   input  adm_pkg::cfg_type  cfg,
   output adm_pkg::emit_type emit,
   input  logic              out_free
);
   import adm_pkg::*;

   localparam int STK_W = $bits(stack_entry_type);

   walk_state_type state_ff, state_in;

   logic [MAX_NODES-1:0] adj_vld_ff;
   logic [MAX_NODES-1:0] visited_ff;
   logic [CNT_W-1:0]     depth_ff;
   logic [VTX_W-1:0]     top_vtx_ff;
   logic [CNT_W-1:0]     top_scan_ff;
   logic [VERTEX_W-1:0]  pend_vtx_ff;

   // RAM ports
   logic                  adj_we, adj_re;
   logic [VTX_W-1:0]      adj_waddr, adj_raddr;
   logic [ROW_BITS_W-1:0] adj_rdata;
   logic                  stk_we, stk_re;
   logic [VTX_W-1:0]      stk_addr;
   stack_entry_type       stk_wdata, stk_rdata;

   // Scan datapath
   logic [MAX_NODES-1:0]    row, cand;
   first_set_type           hit;
   logic                    push_ok, bad_start, row_in_range;
   logic [NODE_COUNT_W-1:0] n_eff;
   logic [CNT_W-1:0]        depth_m1;
   logic [VTX_W-1:0]        start_idx;

   assign n_eff = (int'(cfg.node_count) > MAX_NODES) ? NODE_COUNT_W'(MAX_NODES)
                                                     : cfg.node_count;
   assign bad_start = (cfg.start_vertex == '0) || (cfg.start_vertex > n_eff);
   assign start_idx = VTX_W'(cfg.start_vertex - NODE_COUNT_W'(1));
   assign depth_m1  = depth_ff - CNT_W'(1);

   assign row  = MAX_NODES'(adj_rdata) & {MAX_NODES{adj_vld_ff[top_vtx_ff]}};
   assign cand = row & in_use_mask(n_eff) & ~visited_ff & scan_mask(top_scan_ff);
   assign hit  = first_set(cand);
   assign push_ok = hit.found && (int'(depth_ff) < MAX_NODES);

   assign row_in_range = int'(load.row_index) < MAX_NODES;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         W_IDLE: begin
            if (load.valid && load.last_row) state_in = W_START;
         end
         W_START: begin
            if (!bad_start)    state_in = W_PUSH;
            else if (out_free) state_in = W_IDLE;
         end
         W_PUSH:  state_in = W_SCAN;
         W_SCAN: begin
            if (push_ok) begin
               if (out_free) state_in = W_PUSH;
            end else if (depth_ff != CNT_W'(1)) begin
               state_in = W_RDSTK;
            end else if (out_free) begin
               state_in = W_IDLE;
            end
         end
         W_RDSTK: state_in = W_RDADJ;
         W_RDADJ: state_in = W_SCAN;
         default: state_in = W_IDLE;
      endcase
   end

   // Outputs and memory controls
   always_comb begin
      load_ready  = 1'b0;
      emit        = '0;
      adj_we      = 1'b0;
      adj_waddr   = VTX_W'(load.row_index);
      adj_re      = 1'b0;
      adj_raddr   = top_vtx_ff;
      stk_we      = 1'b0;
      stk_re      = 1'b0;
      stk_addr    = depth_m1[VTX_W-1:0];
      stk_wdata   = '{vertex: top_vtx_ff, scan: '0};
      unique case (state_ff)
         W_IDLE: begin
            load_ready = 1'b1;
            adj_we     = load.valid && row_in_range;
         end
         W_START: begin
            if (bad_start && out_free) begin
               emit = '{valid: 1'b1, vertex: '0, last: 1'b1};
            end
         end
         W_PUSH: begin
            stk_we = 1'b1;
            adj_re = 1'b1;
         end
         W_SCAN: begin
            if (push_ok && out_free) begin
               emit      = '{valid: 1'b1, vertex: pend_vtx_ff, last: 1'b0};
               stk_we    = 1'b1;
               stk_wdata = '{vertex: top_vtx_ff,
                             scan: CNT_W'(hit.index) + CNT_W'(1)};
            end else if (!push_ok && depth_ff == CNT_W'(1) && out_free) begin
               emit = '{valid: 1'b1, vertex: pend_vtx_ff, last: 1'b1};
            end
         end
         W_RDSTK: begin
            stk_re = 1'b1;
         end
         W_RDADJ: begin
            adj_re    = 1'b1;
            adj_raddr = stk_rdata.vertex;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= W_IDLE;
         adj_vld_ff <= '0;
         visited_ff <= '0;
         depth_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (adj_we) begin
            adj_vld_ff[adj_waddr] <= 1'b1;
         end
         unique case (state_ff)
            W_START: begin
               if (bad_start) begin
                  visited_ff <= '0;
                  depth_ff   <= '0;
               end else begin
                  visited_ff <= MAX_NODES'(1) << start_idx;
                  depth_ff   <= CNT_W'(1);
               end
            end
            W_SCAN: begin
               if (push_ok && out_free) begin
                  visited_ff <= visited_ff | (MAX_NODES'(1) << hit.index);
                  depth_ff   <= depth_ff + CNT_W'(1);
               end else if (!push_ok && (depth_ff != CNT_W'(1) || out_free)) begin
                  depth_ff <= depth_m1;
               end
            end
            default: ;
         endcase
      end
   end

   // Top-of-stack cache and the vertex held back for its last flag
   always_ff @(posedge clock) begin
      unique case (state_ff)
         W_START: begin
            top_vtx_ff  <= start_idx;
            top_scan_ff <= '0;
            pend_vtx_ff <= cfg.start_vertex;
         end
         W_SCAN: begin
            if (push_ok && out_free) begin
               top_vtx_ff  <= hit.index;
               top_scan_ff <= '0;
               pend_vtx_ff <= VERTEX_W'(hit.index) + VERTEX_W'(1);
            end
         end
         W_RDADJ: begin
            top_vtx_ff  <= stk_rdata.vertex;
            top_scan_ff <= stk_rdata.scan;
         end
         default: ;
      endcase
   end

   adm_ram #(
      .WIDTH (ROW_BITS_W),
      .DEPTH (MAX_NODES)
   ) u_adj_ram (
      .clock (clock),
      .we    (adj_we),
      .waddr (adj_waddr),
      .wdata (load.row_bits),
      .re    (adj_re),
      .raddr (adj_raddr),
      .rdata (adj_rdata)
   );

   adm_ram #(
      .WIDTH (STK_W),
      .DEPTH (MAX_NODES)
   ) u_stack_ram (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_addr),
      .wdata (stk_wdata),
      .re    (stk_re),
      .raddr (stk_addr),
      .rdata (stk_rdata)
   );
endmodule

FILE: bench/dfs_visit_checker.sv
module dfs_visit_checker (
   input  logic                            clock,
   input  logic                            reset,
   adm_req_if                              req_mon,
   adm_rsp_if                              rsp_mon,
   input  logic                            csr_we,
   input  logic [adm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [adm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int unsigned                     mismatch_total,
   output int unsigned                     visits_pending
);
   import adm_pkg::*;

   typedef struct packed {
      logic [VERTEX_W-1:0] vertex;
      logic                last_visit;
   } dfs_visit_type;

   logic [ROW_BITS_W-1:0]   matrix_rows [MAX_NODES];
   logic [NODE_COUNT_W-1:0] node_limit;
   logic [NODE_COUNT_W-1:0] origin_vertex;
   dfs_visit_type           expected_visits [$];

   // Walk the stored matrix depth-first and queue every vertex it reaches, or a lone vertex 0 for a bad start.
   task automatic predict_walk();
      logic [MAX_NODES-1:0] reach;
      logic [MAX_NODES-1:0] seen;
      logic [MAX_NODES-1:0] cand;
      int                   path_vtx  [MAX_NODES];
      int                   path_scan [MAX_NODES];
      int                   n;
      int                   depth;
      int                   k;
      dfs_visit_type        visit;
      n = (node_limit > MAX_NODES) ? MAX_NODES : int'(node_limit);
      for (int i = 0; i < MAX_NODES; i++) begin
         reach[i] = (i < n);
      end
      if (origin_vertex == 0 || int'(origin_vertex) > n) begin
         visit.vertex     = '0;
         visit.last_visit = 1'b1;
         expected_visits.push_back(visit);
         return;
      end
      seen                  = '0;
      path_vtx[0]           = int'(origin_vertex) - 1;
      path_scan[0]          = 0;
      depth                 = 1;
      seen[path_vtx[0]]     = 1'b1;
      visit.vertex          = origin_vertex;
      visit.last_visit      = 1'b0;
      expected_visits.push_back(visit);
      while (depth > 0) begin
         cand = matrix_rows[path_vtx[depth-1]] & reach & ~seen;
         k    = path_scan[depth-1];
         while (k < n && !cand[k]) begin
            k++;
         end
         if (k < n) begin
            path_scan[depth-1] = k + 1;
            path_vtx[depth]    = k;
            path_scan[depth]   = 0;
            depth++;
            seen[k]            = 1'b1;
            visit.vertex       = VERTEX_W'(k + 1);
            expected_visits.push_back(visit);
         end else begin
            depth--;
         end
      end
      expected_visits[expected_visits.size()-1].last_visit = 1'b1;
   endtask

   always @(posedge clock) begin
      dfs_visit_type want;
      if (reset) begin
         for (int i = 0; i < MAX_NODES; i++) begin
            matrix_rows[i] = '0;
         end
         node_limit    = NODE_COUNT_W'(16);
         origin_vertex = NODE_COUNT_W'(1);
         expected_visits.delete();
         mismatch_total = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_visits.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= 10)
                  $display("unexpected visit: vertex %0d last %0b, nothing pending",
                           rsp_mon.vertex, rsp_mon.last_visit);
            end else begin
               want = expected_visits.pop_front();
               if (rsp_mon.vertex !== want.vertex ||
                   rsp_mon.last_visit !== want.last_visit) begin
                  mismatch_total++;
                  if (mismatch_total <= 10)
                     $display({"visit mismatch: expected vertex %0d last %0b, ",
                               "got vertex %0d last %0b"},
                              want.vertex, want.last_visit, rsp_mon.vertex,
                              rsp_mon.last_visit);
               end
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_NODE_COUNT)
               node_limit = csr_wdata;
            else if (csr_index == CSR_START_VERTEX)
               origin_vertex = csr_wdata;
         end
         if (req_mon.valid && req_mon.ready) begin
            matrix_rows[req_mon.row_index] = req_mon.row_bits;
            if (req_mon.last_row)
               predict_walk();
         end
      end
      visits_pending = expected_visits.size();
   end

endmodule

FILE: bench/tb_top.sv
module tb_top;
   import adm_pkg::*;

   // Graph shapes for the random loads
   localparam int SHAPE_SPARSE = 0;
   localparam int SHAPE_DENSE  = 1;
   localparam int SHAPE_HALF   = 2;
   localparam int SHAPE_CHAIN  = 3;

   // Long response hold-off that backs the block up into its request side
   localparam int HOLD_OFF_CYCLES = 400;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int unsigned mismatch_total;
   int unsigned visits_pending;
   int unsigned items_sent;
   int          send_idle_pct;
   int          recv_stall_pct;
   logic        hold_off_request;
   int          node_cfg;

   adm_req_if req_chan ();
   adm_rsp_if rsp_chan ();

   adjacency_matrix_dfs_order_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   dfs_visit_checker visit_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_total (mismatch_total),
      .visits_pending (visits_pending)
   );

   always #1 clock = ~clock;

   // Hard stop in case the block hangs
   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

   // Response side: stall at random, or hold off for a long stretch on request.
   // Ready changes only at the falling edge, once per cycle.
   initial begin
      int hold_left;
      hold_left      = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left        = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready = 1'b0;
         end else begin
            rsp_chan.ready = ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Offer one row transfer; enter and leave at a falling edge.
   // Valid stays high on exit so back-to-back rows need no gap.
   task automatic send_row(input logic [ROW_INDEX_W-1:0] idx,
                           input logic [ROW_BITS_W-1:0]  bits,
                           input logic                   last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid     = 1'b1;
      req_chan.row_index = idx;
      req_chan.row_bits  = bits;
      req_chan.last_row  = last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   // Drop valid, wait out every pending visit, then let trailing row
   // stores finish so the block is idle.
   task automatic settle_idle();
      req_chan.valid = 1'b0;
      while (visits_pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   // Write both registers while the block is idle.
   task automatic reconfigure(input int n, input int s);
      settle_idle();
      csr_we    = 1'b1;
      csr_index = CSR_NODE_COUNT;
      csr_wdata = CSR_DATA_W'(n);
      @(negedge clock);
      csr_index = CSR_START_VERTEX;
      csr_wdata = CSR_DATA_W'(s);
      @(negedge clock);
      csr_we    = 1'b0;
      node_cfg  = n;
   endtask

   // Pick a setting, mostly legal, sometimes zero or out of range.
   task automatic pick_config();
      int n;
      int lim;
      int s;
      case ($urandom_range(9))
         0:       n = 0;
         1:       n = $urandom_range(17, 31);
         2:       n = 1;
         3, 4:    n = 16;
         default: n = $urandom_range(2, 15);
      endcase
      lim = (n > MAX_NODES) ? MAX_NODES : n;
      case ($urandom_range(9))
         0:       s = 0;
         1:       s = $urandom_range(lim + 1, 31);
         2:       s = lim;
         default: s = $urandom_range(1, (lim == 0) ? 1 : lim);
      endcase
      reconfigure(n, s);
   endtask

   // Load every row in use, in shuffled order; the final row starts the walk.
   task automatic load_graph(input int shape);
      int                    order [MAX_NODES];
      int                    rows;
      int                    j;
      int                    tmp;
      logic [ROW_BITS_W-1:0] bits;
      rows = (node_cfg == 0) ? 1 : ((node_cfg > MAX_NODES) ? MAX_NODES : node_cfg);
      for (int i = 0; i < MAX_NODES; i++) begin
         order[i] = i;
      end
      for (int i = rows - 1; i > 0; i--) begin
         j        = $urandom_range(i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (int i = 0; i < rows; i++) begin
         case (shape)
            SHAPE_SPARSE: bits = ROW_BITS_W'($urandom & $urandom & $urandom);
            SHAPE_DENSE:  bits = ROW_BITS_W'($urandom);
            SHAPE_HALF:   bits = ROW_BITS_W'($urandom & $urandom);
            default: begin
               // path along the load order gives the deepest stack
               bits = ($urandom_range(3) == 0) ? ROW_BITS_W'($urandom & $urandom & $urandom)
                                               : '0;
               if (i < rows - 1)
                  bits[order[i+1]] = 1'b1;
            end
         endcase
         send_row(ROW_INDEX_W'(order[i]), bits, i == rows - 1);
      end
   endtask

   // Broken sequences: a few stray rows, the walk flag set at random.
   task automatic send_noise();
      int burst;
      burst = $urandom_range(1, 4);
      repeat (burst)
         send_row(ROW_INDEX_W'($urandom_range(15)), ROW_BITS_W'($urandom),
                  $urandom_range(2) == 0);
   endtask

   initial begin
      int phase_goal;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.row_index = '0;
      req_chan.row_bits  = '0;
      req_chan.last_row  = 1'b0;
      csr_we             = 1'b0;
      csr_index          = CSR_NODE_COUNT;
      csr_wdata          = '0;
      send_idle_pct      = 0;
      recv_stall_pct     = 0;
      hold_off_request   = 1'b0;
      items_sent         = 0;
      node_cfg           = 16;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         // idle mix: none, sender only, receiver only, both lightly
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
         endcase
         if (phase == 0) begin
            // Reset setting: full fan-out from vertex 1 with a self loop,
            // then a row store without a walk and an isolated start.
            send_row(4'd0, 16'hFFFF, 1'b1);
            send_row(4'd5, 16'hFFFF, 1'b0);
            send_row(4'd0, 16'h0000, 1'b1);
            // Start at the top vertex, self loop on it
            reconfigure(16, 16);
            send_row(4'd15, 16'h8020, 1'b1);
            // Edges at or above the vertex count must be ignored
            reconfigure(3, 2);
            send_row(4'd1, 16'hFFF9, 1'b0);
            send_row(4'd0, 16'hFFFC, 1'b1);
            // Bad starts: zero count, zero start, start above the clamped count
            reconfigure(0, 1);
            send_row(4'd2, 16'h1234, 1'b1);
            reconfigure(16, 0);
            send_row(4'd15, 16'h0000, 1'b1);
            reconfigure(31, 17);
            send_row(4'd4, 16'hA5A5, 1'b1);
            // Count above the matrix clamps to the full graph
            reconfigure(31, 16);
            send_row(4'd15, 16'h7FFF, 1'b1);
            // Smallest graphs
            reconfigure(1, 1);
            send_row(4'd0, 16'hFFFF, 1'b1);
            reconfigure(2, 2);
            send_row(4'd1, 16'h0001, 1'b1);
            // Full-depth chain while the response side holds off: the walk
            // stalls and the rows that follow back up behind it.
            reconfigure(16, 1);
            hold_off_request = 1'b1;
            load_graph(SHAPE_CHAIN);
            // Keep offering rows: a second walk fills the response side for
            // sure, so the trailing row waits for the hold-off to end.
            send_row(4'd0, 16'h0002, 1'b1);
            send_row(4'd3, 16'h0000, 1'b0);
         end
         phase_goal = items_sent + 62;
         while (items_sent < phase_goal) begin
            if ($urandom_range(3) == 0)
               pick_config();
            if ($urandom_range(4) == 0)
               send_noise();
            else
               load_graph($urandom_range(SHAPE_CHAIN));
         end
         settle_idle();
      end

      // let any stray transfer show up before the verdict
      repeat (40) @(negedge clock);
      if (mismatch_total == 0 && visits_pending == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
